// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the vector angle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a consequent sequence follows whenever the antecedent holds.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/vad_pkg.sv =====
// Package with the constants and arctangent table of the vector angle block.
package vad_pkg;

  // Default configuration of the datapath.
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_COORD_WIDTH  = 16;

  // Fraction bits added below the coordinates before iterating.
  localparam int GUARD_BITS = 8;

  // Width of the binary angle accumulator (one turn is 2^32).
  localparam int ZW = 32;

  // Width of the rounded binary angle (one turn is 2^16).
  localparam int AW = 16;

  // Width of the angle in degrees.
  localparam int DW = 9;

  // Degrees in one turn.
  localparam logic [DW-1:0] DEG_PER_TURN = 9'd360;

  // Half a turn in accumulator units.
  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  // Number of entries in the arctangent table.
  localparam int ATAN_TABLE_SIZE = 24;

  // atan(2^-i) in accumulator units, rounded to nearest.
  localparam logic [ZW-1:0] ATAN_TURN32 [ATAN_TABLE_SIZE] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// ===== hw/rtl/vad_cordic.sv =====
// Pipelined CORDIC vectoring lane that turns one vector into a 16-bit binary angle.
module vad_cordic import vad_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [COORD_WIDTH-1:0] x,
  input  logic [COORD_WIDTH-1:0] y,
  output logic                   out_valid,
  output logic [AW-1:0]          angle
);

  // Iterations actually run, limited by the table.
  localparam int STEPS = (CORDIC_STEPS > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE : CORDIC_STEPS;
  // Sign-extended coordinate width, room for negation and CORDIC gain.
  localparam int EW = COORD_WIDTH + 2;
  // Working width with guard bits.
  localparam int XW = EW + GUARD_BITS;

  logic signed [XW-1:0] x_pipe [STEPS+1];
  logic signed [XW-1:0] y_pipe [STEPS+1];
  logic [ZW-1:0]        z_pipe [STEPS+1];
  logic                 zero_pipe [STEPS+1];
  logic                 vld_pipe [STEPS+1];

  logic signed [EW-1:0] x_ext;
  logic signed [EW-1:0] y_ext;
  logic                 x_neg;
  logic                 is_zero;

  // Sign extension, left half-plane fold and zero detection.
  assign x_ext   = {{(EW-COORD_WIDTH){x[COORD_WIDTH-1]}}, x};
  assign y_ext   = {{(EW-COORD_WIDTH){y[COORD_WIDTH-1]}}, y};
  assign x_neg   = x[COORD_WIDTH-1];
  assign is_zero = (x == '0) && (y == '0);

  // Entry stage: fold into the right half-plane and add guard bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe[0] <= 1'b0;
    end else begin
      vld_pipe[0] <= in_valid;
    end
    x_pipe[0]    <= x_neg ? {-x_ext, {GUARD_BITS{1'b0}}} : {x_ext, {GUARD_BITS{1'b0}}};
    y_pipe[0]    <= x_neg ? {-y_ext, {GUARD_BITS{1'b0}}} : {y_ext, {GUARD_BITS{1'b0}}};
    z_pipe[0]    <= x_neg ? HALF_TURN : '0;
    zero_pipe[0] <= is_zero;
  end

  // One register stage per micro-rotation; the shift by k is fixed wiring.
  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 y_pos;

    assign dx    = y_pipe[k] >>> k;
    assign dy    = x_pipe[k] >>> k;
    assign y_pos = !y_pipe[k][XW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_pipe[k+1] <= 1'b0;
      end else begin
        vld_pipe[k+1] <= vld_pipe[k];
      end
      if (y_pos) begin
        x_pipe[k+1] <= x_pipe[k] + dx;
        y_pipe[k+1] <= y_pipe[k] - dy;
        z_pipe[k+1] <= z_pipe[k] + ATAN_TURN32[k];
      end else begin
        x_pipe[k+1] <= x_pipe[k] - dx;
        y_pipe[k+1] <= y_pipe[k] + dy;
        z_pipe[k+1] <= z_pipe[k] - ATAN_TURN32[k];
      end
      zero_pipe[k+1] <= zero_pipe[k];
    end
  end

  // Round the accumulator to 16 bits; a zero vector has angle zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_pipe[STEPS];
    end
    if (zero_pipe[STEPS]) begin
      angle <= '0;
    end else begin
      angle <= z_pipe[STEPS][ZW-1:ZW-AW] + {{(AW-1){1'b0}}, z_pipe[STEPS][ZW-AW-1]};
    end
  end

endmodule

// ===== hw/rtl/vector_angle_degrees_top.sv =====
// Top level of the vector angle block: two CORDIC lanes, difference and degree scaling.
//
// Usage: drive first_x/first_y/second_x/second_y and raise start for one cycle
// per item. An item is accepted at each rising edge where start is high and
// busy is low; busy is always low, so a new beat can be taken on every clock.
// Each result appears on angle_degrees with done high for exactly one cycle,
// after passing through the registered stages in order: one entry stage, one
// stage per CORDIC micro-rotation, one rounding stage, one difference stage
// and one scaling stage. Throughput is one item per cycle, set by the fully
// unrolled micro-rotation stages of the two lanes.
// The result is the counter-clockwise angle from the second vector to the
// first in whole degrees, 0 to 360; a zero vector counts as angle zero.
// Reset clears every valid bit, so no done strobe comes from items in flight
// at reset. The receiver cannot stall: each result is taken in its cycle.
`include "assert_macros.svh"

module vector_angle_degrees_top import vad_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] first_x,
  input  logic [COORD_WIDTH-1:0] first_y,
  input  logic [COORD_WIDTH-1:0] second_x,
  input  logic [COORD_WIDTH-1:0] second_y,
  output logic                   done,
  output logic [DW-1:0]          angle_degrees
);

  localparam int STEPS   = (CORDIC_STEPS > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE : CORDIC_STEPS;
  localparam int LATENCY = STEPS + 4;
  localparam int PW      = AW + DW;

  logic          accept;
  logic          a_valid;
  logic          b_valid;
  logic [AW-1:0] a_angle;
  logic [AW-1:0] b_angle;
  logic          diff_valid;
  logic [AW-1:0] diff;
  logic [PW-1:0] scaled;

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Direction of the first vector.
  vad_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_first (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .x         (first_x),
    .y         (first_y),
    .out_valid (a_valid),
    .angle     (a_angle)
  );

  // Direction of the second vector.
  vad_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .x         (second_x),
    .y         (second_y),
    .out_valid (b_valid),
    .angle     (b_angle)
  );

  // Angle difference, wrapped modulo one turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
    end else begin
      diff_valid <= a_valid && b_valid;
    end
    diff <= a_angle - b_angle;
  end

  // Scale to degrees with round-half-up: (diff * 360 + 2^15) >> 16.
  assign scaled = {{DW{1'b0}}, diff} * {{AW{1'b0}}, DEG_PER_TURN}
                + {{(PW-AW){1'b0}}, 1'b1, {(AW-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= diff_valid;
    end
    angle_degrees <= scaled[PW-1:AW];
  end

  `ASSERT_ALWAYS(a_lanes_agree, clk, rst, a_valid == b_valid, "CORDIC lanes out of step")
  `ASSERT_IMPLY(a_start_done, clk, rst, accept, ##LATENCY done, "accepted beat gave no result")
  `ASSERT_IMPLY(a_done_start, clk, rst, done, $past(accept, LATENCY), "result without a beat")
  `ASSERT_IMPLY(a_range, clk, rst, done, angle_degrees <= DEG_PER_TURN, "angle above 360")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the vector angle block: random and directed vector pairs.
module tb_top import vad_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = DEF_COORD_WIDTH;
  localparam int STEPS = DEF_CORDIC_STEPS;
  localparam int RANDOM_PAIRS = 1300;
  localparam int SETTLE_CYCLES = STEPS + 12;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_COORD = 32767;
  localparam int MIN_COORD = -32768;

  // One input beat: two vectors.
  typedef struct {
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
  } vec_pair_t;

  // Micro-rotation angles, atan(2^-i) with one turn equal to 2^32.
  localparam logic [31:0] ROT_ANGLE [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;
  logic                 done;
  logic [DW-1:0]        angle_degrees;

  vec_pair_t     pending_pairs[$];
  logic [DW-1:0] expected_angles[$];
  int            fail_count = 0;
  int            beats_taken = 0;
  int            beats_queued = 0;
  int            idle_left = 0;
  int            burst_left = 0;
  int            stall_cycles = 0;
  logic          beat_taken = 1'b0;

  vector_angle_degrees_top DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .first_x       (first_x),
    .first_y       (first_y),
    .second_x      (second_x),
    .second_y      (second_y),
    .done          (done),
    .angle_degrees (angle_degrees)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Direction of one vector as a 16-bit binary angle, found by CORDIC vectoring.
  function automatic logic [15:0] direction_turn16(logic signed [CW-1:0] vx,
                                                   logic signed [CW-1:0] vy);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [31:0] z;
    logic [32:0] rounded;
    int          steps;
    x = vx;
    y = vy;
    z = '0;
    steps = (STEPS > 24) ? 24 : STEPS;
    if (x == 0 && y == 0) begin
      return '0;
    end
    // The left half-plane is folded over by half a turn.
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    x = x * (longint'(1) << GUARD_BITS);
    y = y * (longint'(1) << GUARD_BITS);
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      // A residual y of zero rotates clockwise.
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ROT_ANGLE[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ROT_ANGLE[i];
      end
    end
    rounded = {1'b0, z} + 33'h8000;
    return rounded[31:16];
  endfunction

  // Counter-clockwise angle from the second vector to the first in whole degrees.
  function automatic logic [DW-1:0] angle_between(vec_pair_t p);
    logic [15:0] diff;
    logic [31:0] scaled;
    diff = direction_turn16(p.fx, p.fy) - direction_turn16(p.sx, p.sy);
    scaled = 32'(diff) * 32'd360 + 32'd32768;
    return scaled[24:16];
  endfunction

  function automatic int clamp_coord(int v);
    if (v > MAX_COORD) return MAX_COORD;
    if (v < MIN_COORD) return MIN_COORD;
    return v;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 6))
      0: return MIN_COORD;
      1: return MIN_COORD + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return MAX_COORD - 1;
      default: return MAX_COORD;
    endcase
  endfunction

  task automatic add_pair(int fx, int fy, int sx, int sy);
    vec_pair_t p;
    p.fx = fx[CW-1:0];
    p.fy = fy[CW-1:0];
    p.sx = sx[CW-1:0];
    p.sy = sy[CW-1:0];
    pending_pairs.push_back(p);
    beats_queued++;
  endtask

  // Random pair drawn from a mix of full-range, small, extreme, near-parallel, zero and on-axis vectors.
  task automatic add_random_pair();
    int mode;
    int fx;
    int fy;
    int sx;
    int sy;
    mode = $urandom_range(0, 99);
    fx = $signed(16'($urandom));
    fy = $signed(16'($urandom));
    sx = $signed(16'($urandom));
    sy = $signed(16'($urandom));
    if (mode < 15) begin
      fx = $urandom_range(0, 16) - 8;
      fy = $urandom_range(0, 16) - 8;
      sx = $urandom_range(0, 16) - 8;
      sy = $urandom_range(0, 16) - 8;
    end else if (mode < 25) begin
      fx = extreme_coord();
      fy = extreme_coord();
      sx = extreme_coord();
      sy = extreme_coord();
    end else if (mode < 50) begin
      // Nearly equal directions land on the wrap between 0 and 360 degrees.
      sx = clamp_coord(fx + $urandom_range(0, 6) - 3);
      sy = clamp_coord(fy + $urandom_range(0, 6) - 3);
    end else if (mode < 55) begin
      fx = 0;
      fy = 0;
    end else if (mode < 60) begin
      sx = 0;
      sy = 0;
    end else if (mode < 65) begin
      // Vectors on the axes, with the left half-plane and a zero y component.
      fy = 0;
      sx = 0;
    end
    add_pair(fx, fy, sx, sy);
  endtask

  // Driver: presents one beat at a time and may idle between beats.
  always @(negedge clk) begin : drive_beats
    vec_pair_t p;
    int        r;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      start <= 1'b1;
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (pending_pairs.size() > 0) begin
      p = pending_pairs.pop_front();
      first_x <= p.fx;
      first_y <= p.fy;
      second_x <= p.sx;
      second_y <= p.sy;
      start <= 1'b1;
      // Gap before the next beat: none in bursts and often otherwise, else mostly short.
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
        idle_left <= 0;
      end else if (r < 3) begin
        burst_left <= $urandom_range(20, 80);
        idle_left <= 0;
      end else if (r < 55) begin
        idle_left <= 0;
      end else if (r < 92) begin
        idle_left <= $urandom_range(1, 3);
      end else begin
        idle_left <= $urandom_range(8, 40);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Accepted beats queue their expected angle.
  always @(posedge clk) begin
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (start && !busy) begin
        expected_angles.push_back(angle_between('{first_x, first_y, second_x, second_y}));
        beats_taken <= beats_taken + 1;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    logic [DW-1:0] want;
    if (!rst && done) begin
      if (expected_angles.size() == 0) begin
        $error("angle_degrees: result %0d with no beat outstanding", angle_degrees);
        fail_count <= fail_count + 1;
      end else begin
        want = expected_angles.pop_front();
        if (angle_degrees !== want) begin
          $error("angle_degrees: expected %0d, actual %0d", want, angle_degrees);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // Watchdog: ends the run when neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    rst = 1'b1;
    start = 1'b0;
    first_x = '0;
    first_y = '0;
    second_x = '0;
    second_y = '0;

    // Directed pairs: zero vectors, axes, extremes and the wrap near a full turn.
    add_pair(0, 0, 0, 0);
    add_pair(1, 0, 0, 0);
    add_pair(0, 0, 32767, 32767);
    add_pair(0, 1, 1, 0);
    add_pair(-1, 0, 1, 0);
    add_pair(0, -1, 1, 0);
    add_pair(1, 0, 0, 1);
    add_pair(-32768, 0, 0, -32768);
    add_pair(32767, 32767, -32768, -32768);
    add_pair(-32768, -32768, 32767, 32767);
    add_pair(32767, -32768, -32768, 32767);
    add_pair(-32768, 32767, 32767, -32768);
    add_pair(32767, -1, 32767, 0);
    add_pair(32767, 0, 32767, 1);
    add_pair(-32768, -1, -32768, 0);
    add_pair(-32768, 1, -32768, -1);
    add_pair(-1, -1, -1, 1);
    add_pair(1, -1, 1, 1);
    add_pair(-32768, 0, -32768, 0);
    add_pair(32767, 32767, 32767, 32767);
    add_pair(-1, 0, -32768, 0);
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      add_random_pair();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (beats_taken < beats_queued || expected_angles.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
